// ===== rtl/rcss_pkg.sv =====
// rcss_pkg: sizes, status codes and request/response types for the
// refcounted slot stack. No dependencies.
`timescale 1ns / 1ps

package rcss_pkg;

	localparam int NUM_SLOTS      = 16;
	localparam int NUM_REQUESTERS = 16;
	localparam int COUNT_BITS     = 8;

	localparam int SLOT_W     = 4;                       // slot number field width
	localparam int REQ_W      = 4;                       // requester field width
	localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
	localparam int REQ_IDX_W  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
	localparam int TOP_W      = $clog2(NUM_SLOTS + 1);   // stack depth 0..NUM_SLOTS

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic {
		OP_GET = 1'b0,
		OP_RET = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_FULL      = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [REQ_W-1:0]  requester;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} rsp_t;

endpackage

// ===== rtl/refcounted_slot_stack.sv =====
// Refcounted slot stack: one request accepted every cycle, busy stays low.
// done is registered: a request passes the input register, then the state update and
// result register in one pass.
// Throughput: one request per cycle, set by the core, whose decision is combinational.
// Reset: async, active low; stack holds slots 0..15, all counts zero.
// done is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps

module refcounted_slot_stack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [rcss_pkg::REQ_W-1:0]  requester,
	input  logic [rcss_pkg::SLOT_W-1:0] slot_in,
	output logic                        done,
	output logic [rcss_pkg::SLOT_W-1:0] slot_out,
	output logic [2:0]                  status
);
	import rcss_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	rsp_t  rsp;
	logic  done_q;
	rsp_t  rsp_q;
	logic  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op        <= op_t'(operation);
			req_s1.requester <= requester;
			req_s1.slot      <= slot_in;
		end
	end

	rcss_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s1),
		.req       (req_s1),
		.rsp       (rsp)
	);

	// outputs read zero between strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rsp_q  <= '0;
		end else begin
			done_q <= valid_s1;
			rsp_q  <= valid_s1 ? rsp : '0;
		end
	end

	assign done     = done_q;
	assign slot_out = rsp_q.slot;
	assign status   = rsp_q.status;

endmodule

// ===== rtl/rcss_core.sv =====
// rcss_core: free-slot stack, per-requester counts and held slots, and the
// combinational get/return decision. Depends on rcss_pkg.
`timescale 1ns / 1ps

module rcss_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  rcss_pkg::req_t req,
	output rcss_pkg::rsp_t rsp
);
	import rcss_pkg::*;

	logic [SLOT_W-1:0]     free_stack_q [NUM_SLOTS];
	logic [TOP_W-1:0]      stack_top_q;
	logic [COUNT_BITS-1:0] hold_count_q [NUM_REQUESTERS];
	logic [SLOT_W-1:0]     held_slot_q  [NUM_REQUESTERS];
	logic                  held_valid_q [NUM_REQUESTERS];

	logic [REQ_IDX_W-1:0]  r_idx;
	logic [TOP_W-1:0]      top_dec;
	logic [SLOT_IDX_W-1:0] pop_idx;
	logic [SLOT_IDX_W-1:0] push_idx;
	logic [COUNT_BITS-1:0] cnt;
	logic [SLOT_W-1:0]     pop_slot;

	logic do_pop, do_push, do_inc, do_dec;

	assign r_idx    = REQ_IDX_W'(req.requester % NUM_REQUESTERS);
	assign top_dec  = stack_top_q - TOP_W'(1);
	assign pop_idx  = top_dec[SLOT_IDX_W-1:0];
	assign push_idx = stack_top_q[SLOT_IDX_W-1:0];
	assign cnt      = hold_count_q[r_idx];
	assign pop_slot = free_stack_q[pop_idx];

	always_comb begin
		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_inc     = 1'b0;
		do_dec     = 1'b0;
		rsp.slot   = '0;
		rsp.status = ST_OK;
		case (req.op)
			OP_GET: begin
				if (cnt == COUNT_MAX) begin
					rsp.status = ST_SATURATED;
				end else if (!held_valid_q[r_idx]) begin
					if (stack_top_q == '0) begin
						rsp.status = ST_EMPTY;
					end else begin
						do_pop   = 1'b1;
						do_inc   = 1'b1;
						rsp.slot = pop_slot;
					end
				end else begin
					do_inc   = 1'b1;
					rsp.slot = held_slot_q[r_idx];
				end
			end
			OP_RET: begin
				if (cnt == '0) begin
					rsp.status = ST_UNDERFLOW;
				end else if (cnt == COUNT_BITS'(1)) begin
					if (stack_top_q >= TOP_W'(NUM_SLOTS)) begin
						rsp.status = ST_FULL;
					end else begin
						do_push = 1'b1;
						do_dec  = 1'b1;
					end
				end else begin
					do_dec = 1'b1;
				end
			end
			default: begin
				rsp.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				free_stack_q[i] <= SLOT_W'(i);
			end
			stack_top_q <= TOP_W'(NUM_SLOTS);
			for (int i = 0; i < NUM_REQUESTERS; i++) begin
				hold_count_q[i] <= '0;
				held_slot_q[i]  <= '0;
				held_valid_q[i] <= 1'b0;
			end
		end else if (req_valid) begin
			if (do_pop) begin
				stack_top_q         <= top_dec;
				held_slot_q[r_idx]  <= pop_slot;
				held_valid_q[r_idx] <= 1'b1;
			end
			if (do_push) begin
				// returned slot goes back as given, held or not
				free_stack_q[push_idx] <= req.slot;
				stack_top_q            <= stack_top_q + TOP_W'(1);
				held_slot_q[r_idx]     <= '0;
				held_valid_q[r_idx]    <= 1'b0;
			end
			if (do_inc) begin
				hold_count_q[r_idx] <= cnt + COUNT_BITS'(1);
			end
			if (do_dec) begin
				hold_count_q[r_idx] <= cnt - COUNT_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/rcss_checker.sv =====
// rcss_checker: port-level checks for refcounted_slot_stack, with bind.
// Depends on rcss_pkg.
`timescale 1ns / 1ps

module rcss_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [rcss_pkg::SLOT_W-1:0] slot_out,
	input logic [2:0]                  status
);
	import rcss_pkg::*;

	// every accepted request yields a strobe through the input and result registers
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted request produced no result");

	// no strobe without an earlier accepted request
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a request");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_SATURATED))
		else $error("status code out of range");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (slot_out == '0))
		else $error("slot granted on a failed request");

endmodule

bind refcounted_slot_stack rcss_checker u_rcss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.slot_out (slot_out),
	.status   (status)
);

// ===== tb/sv/refcounted_slot_stack_tb.sv =====
// Testbench for refcounted_slot_stack: directed and random get/return requests
// checked against a predictor of the slot stack. Depends on rcss_pkg and the RTL top.
`timescale 1ns / 1ps

module refcounted_slot_stack_tb;
	import rcss_pkg::*;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		status_t           code;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                operation = 1'b0;
	logic [REQ_W-1:0]    requester = '0;
	logic [SLOT_W-1:0]   slot_in = '0;
	logic                busy;
	logic                done;
	logic [SLOT_W-1:0]   slot_out;
	logic [2:0]          status;

	// predictor state
	logic [SLOT_W-1:0]     free_slots [NUM_SLOTS];
	int                    depth;
	logic [COUNT_BITS-1:0] use_cnt [NUM_REQUESTERS];
	logic [SLOT_W-1:0]     owned [NUM_REQUESTERS];
	logic                  owns [NUM_REQUESTERS];

	req_t   req_backlog [$];
	grant_t owed_grants [$];
	int     gen_cnt [NUM_REQUESTERS];
	int     n_total = 0;
	int     n_taken = 0;
	int     n_mismatch = 0;
	int     gap_left = 0;
	int     burst_left = 0;
	grant_t predicted;
	grant_t want;

	refcounted_slot_stack dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operation(operation),
		.requester(requester),
		.slot_in  (slot_in),
		.done     (done),
		.slot_out (slot_out),
		.status   (status)
	);

	always #2 clk = ~clk;

	function automatic grant_t predict_grant(input op_t op, input logic [REQ_W-1:0] who_raw,
			input logic [SLOT_W-1:0] give_back);
		grant_t g;
		int     idx;
		idx = int'(who_raw) % NUM_REQUESTERS;
		g.slot = '0;
		g.code = ST_OK;
		if (op == OP_GET) begin
			if (use_cnt[idx] == COUNT_MAX)
				g.code = ST_SATURATED;
			else if (!owns[idx] && depth == 0)
				g.code = ST_EMPTY;
			else begin
				if (!owns[idx]) begin
					depth--;
					owned[idx] = free_slots[depth];
					owns[idx] = 1'b1;
				end
				use_cnt[idx]++;
				g.slot = owned[idx];
			end
		end else begin
			if (use_cnt[idx] == 0)
				g.code = ST_UNDERFLOW;
			else if (use_cnt[idx] == 1 && depth >= NUM_SLOTS)
				g.code = ST_FULL;
			else begin
				// last reference: slot goes back as given, not necessarily the one held
				if (use_cnt[idx] == 1) begin
					owns[idx] = 1'b0;
					owned[idx] = '0;
					free_slots[depth] = give_back;
					depth++;
				end
				use_cnt[idx]--;
			end
		end
		return g;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0)
			burst_left = 40;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic add_item(input op_t op, input logic [REQ_W-1:0] who,
			input logic [SLOT_W-1:0] s);
		req_t it;
		it.op = op;
		it.requester = who;
		it.slot = s;
		req_backlog.push_back(it);
		n_total++;
		if (op == OP_GET && gen_cnt[who] < int'(COUNT_MAX))
			gen_cnt[who]++;
		else if (op == OP_RET && gen_cnt[who] > 0)
			gen_cnt[who]--;
	endtask

	// driver: one request presented at a time, held until taken
	always @(posedge clk) begin
		req_t it;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predicted = predict_grant(op_t'(operation), requester, slot_in);
				owed_grants.push_back(predicted);
				n_taken++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (req_backlog.size() != 0) begin
				it = req_backlog.pop_front();
				start <= 1'b1;
				operation <= it.op;
				requester <= it.requester;
				slot_in <= it.slot;
				gap_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_grants.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: slot %0d code %0d", slot_out, status);
			end else begin
				want = owed_grants.pop_front();
				if (slot_out !== want.slot || status !== want.code) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: slot exp %0d got %0d, code exp %0d got %0d",
							want.slot, slot_out, want.code, status);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++)
			free_slots[i] = SLOT_W'(i);
		depth = NUM_SLOTS;
		for (int i = 0; i < NUM_REQUESTERS; i++) begin
			use_cnt[i] = '0;
			owned[i] = '0;
			owns[i] = 1'b0;
			gen_cnt[i] = 0;
		end

		// directed: reuse of held slot, release to zero, underflow, foreign slot pushed back
		add_item(OP_GET, 4'd0, 4'd0);
		add_item(OP_GET, 4'd0, 4'd9);
		add_item(OP_RET, 4'd0, 4'd0);
		add_item(OP_RET, 4'd0, 4'd15);
		add_item(OP_RET, 4'd0, 4'd7);
		add_item(OP_GET, 4'd15, 4'd15);
		add_item(OP_RET, 4'd15, 4'd0);
		// every requester takes a slot: stack drains to empty
		for (int i = 0; i < NUM_REQUESTERS; i++)
			add_item(OP_GET, REQ_W'(i), REQ_W'(~i));
		add_item(OP_RET, 4'd3, 4'hA);
		add_item(OP_GET, 4'd3, 4'd0);

		// count saturation on one requester, then release past zero
		for (int i = 0; i < 260; i++)
			add_item(OP_GET, 4'd9, SLOT_W'($urandom_range(0, 15)));
		for (int i = 0; i < 262; i++)
			add_item(OP_RET, 4'd9, SLOT_W'($urandom_range(0, 15)));

		// random: mostly balanced get/return traffic, some noise
		for (int i = 0; i < 450; i++) begin
			logic [REQ_W-1:0]  who;
			logic [SLOT_W-1:0] s;
			who = REQ_W'($urandom_range(0, 15));
			s = SLOT_W'($urandom_range(0, 15));
			if ($urandom_range(0, 99) < 12)
				add_item(op_t'($urandom_range(0, 1)), who, s);
			else if (gen_cnt[who] == 0)
				add_item(($urandom_range(0, 99) < 90) ? OP_GET : OP_RET, who, s);
			else
				add_item(($urandom_range(0, 99) < 48) ? OP_RET : OP_GET, who, s);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_total)
			@(posedge clk);
		while (owed_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_mismatch == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rcss_pkg.sv
rtl/rcss_core.sv
rtl/refcounted_slot_stack.sv
rtl/rcss_checker.sv
tb/sv/refcounted_slot_stack_tb.sv
